/* design/local_lru_frame_replacement_defines.svh */
// Assertion macros used by the frame replacement checker.
`ifndef LOCAL_LRU_FRAME_REPLACEMENT_DEFINES_SVH
`define LOCAL_LRU_FRAME_REPLACEMENT_DEFINES_SVH

// same-cycle implication
`define LFR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LFR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/lfr_pkg.sv */
// Package: widths, codes, state and interface types of the frame replacement block.
`timescale 1ns / 1ps
package lfr_pkg;

  localparam int PID_W         = 3;
  localparam int FIDX_W        = 6;
  localparam int STAMP_W       = 32;
  localparam int FAULT_W       = 32;
  localparam int STATUS_W      = 2;

  localparam int FRAMES_DEF    = 64;
  localparam int PROCS_DEF     = 8;
  localparam int PAGE_BITS_DEF = 16;

  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_ASSIGN = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_HIT      = 2'd0,
    STAT_REPLACED = 2'd1,
    STAT_NOFRAME  = 2'd2,
    STAT_ASSIGNED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_ADJ,
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_WAIT,
    S_DONE
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_write;
    logic clr_sub;
    logic cnt_inc;
    logic accept;
    logic scan_rd;
    logic finish;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic clr_carry;
    logic adj_more;
    logic start_scan;
    logic scan_last;
  } ctrl_stat_t;

endpackage

/* design/lfr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/lfr_ctrl.sv */
// Controller: sequences the clearing pass, the frame scan and the result.
`timescale 1ns / 1ps
module lfr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  lfr_pkg::ctrl_stat_t sts,
  output lfr_pkg::ctrl_cmd_t  ctl,
  output logic               busy
);
  import lfr_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_CLEAR: begin
        ctl.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end else if (sts.clr_carry) begin
          state_next = S_ADJ;
        end else begin
          ctl.cnt_inc = 1'b1;
        end
      end
      S_ADJ: begin
        ctl.clr_sub = 1'b1;
        if (!sts.adj_more) begin
          ctl.cnt_inc = 1'b1;
          state_next  = S_CLEAR;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctl.accept = 1'b1;
          state_next = sts.start_scan ? S_SCAN : S_WAIT;
        end
      end
      S_SCAN: begin
        ctl.scan_rd = 1'b1;
        ctl.cnt_inc = 1'b1;
        if (sts.scan_last) begin
          state_next = S_LAST;
        end
      end
      S_LAST: state_next = S_DONE;
      S_WAIT: state_next = S_DONE;
      S_DONE: begin
        ctl.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* design/lfr_datapath.sv */
// Datapath: frame table and fault counter memories, scan compare, result registers.
`timescale 1ns / 1ps
module lfr_datapath #(
  parameter int FRAMES    = lfr_pkg::FRAMES_DEF,
  parameter int PROCS     = lfr_pkg::PROCS_DEF,
  parameter int PAGE_BITS = lfr_pkg::PAGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lfr_pkg::ctrl_cmd_t            ctl,
  output lfr_pkg::ctrl_stat_t           sts,
  input  logic                          cmd,
  input  logic [lfr_pkg::PID_W-1:0]     process_id,
  input  logic [PAGE_BITS-1:0]          page,
  input  logic [lfr_pkg::FIDX_W-1:0]    frame_index,
  input  logic [lfr_pkg::STAMP_W-1:0]   time_stamp,
  output logic                          done,
  output logic [lfr_pkg::STATUS_W-1:0]  status,
  output logic [lfr_pkg::FIDX_W-1:0]    frame_hit,
  output logic                          evicted_valid,
  output logic [PAGE_BITS-1:0]          evicted_page,
  output logic [lfr_pkg::FAULT_W-1:0]   fault_total
);
  import lfr_pkg::*;

  localparam int FW     = $clog2(FRAMES);
  localparam int OWN_W  = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int PX_W   = (PID_W > $clog2(PROCS + 1)) ? PID_W : $clog2(PROCS + 1);
  localparam int FX_W   = (FIDX_W > $clog2(FRAMES + 1)) ? FIDX_W : $clog2(FRAMES + 1);
  localparam int REM_W  = $clog2(2 * FRAMES + PROCS + 1);
  localparam int WORD_W = OWN_W + 2 + PAGE_BITS + STAMP_W;

  // request
  logic                 r_cmd;
  logic [PID_W-1:0]     r_pid;
  logic [PAGE_BITS-1:0] r_page;
  logic [FIDX_W-1:0]    r_fidx;
  logic [STAMP_W-1:0]   r_now;

  // shared frame counter, clearing quotient and remainder
  logic [FW-1:0]        cnt;
  logic [REM_W-1:0]     rem;
  logic [OWN_W-1:0]     q;

  // scan pipeline and search results
  logic                 rd_vld;
  logic [FW-1:0]        rd_idx;
  logic                 hit;
  logic [FW-1:0]        hit_idx;
  logic                 have;
  logic [FW-1:0]        best_idx;
  logic                 best_used;
  logic                 best_pv;
  logic [PAGE_BITS-1:0] best_page;
  logic [STAMP_W-1:0]   best_stamp;

  logic [PROCS-1:0]     faults_vld;

  logic                 fr_we;
  logic [FW-1:0]        fr_waddr;
  logic [WORD_W-1:0]    fr_wdata;
  logic [WORD_W-1:0]    fr_rdata;

  logic                 fl_we;
  logic [FAULT_W-1:0]   fl_wdata;
  logic [FAULT_W-1:0]   fl_rdata;

  logic [PX_W-1:0]      pid_x;
  logic [OWN_W-1:0]     pid_own;
  logic                 pid_ok;
  logic [FX_W-1:0]      fidx_x;
  logic                 fidx_ok;
  logic [FAULT_W-1:0]   faults_cur;
  logic [FAULT_W-1:0]   faults_inc;

  logic [OWN_W-1:0]     w_owner;
  logic                 w_pv;
  logic                 w_used;
  logic [PAGE_BITS-1:0] w_page;
  logic [STAMP_W-1:0]   w_stamp;
  logic                 w_own;
  logic                 w_better;

  status_t              res_status;
  logic [FIDX_W-1:0]    res_frame;
  logic                 res_ev;
  logic [PAGE_BITS-1:0] res_evpage;
  logic [FAULT_W-1:0]   res_total;

  function automatic logic [FIDX_W-1:0] fidx_lo(input logic [FW-1:0] idx);
    logic [FX_W-1:0] wide;
    wide = FX_W'(idx);
    return wide[FIDX_W-1:0];
  endfunction

  assign pid_x   = PX_W'(r_pid);
  assign pid_own = pid_x[OWN_W-1:0];
  assign pid_ok  = (pid_x < PX_W'(PROCS));
  assign fidx_x  = FX_W'(r_fidx);
  assign fidx_ok = (fidx_x < FX_W'(FRAMES));

  assign faults_cur = faults_vld[pid_own] ? fl_rdata : '0;
  assign faults_inc = (faults_cur == '1) ? faults_cur : faults_cur + FAULT_W'(1);

  assign w_owner = fr_rdata[WORD_W-1 -: OWN_W];
  assign w_pv    = fr_rdata[PAGE_BITS + STAMP_W + 1];
  assign w_used  = fr_rdata[PAGE_BITS + STAMP_W];
  assign w_page  = fr_rdata[STAMP_W +: PAGE_BITS];
  assign w_stamp = fr_rdata[STAMP_W-1:0];

  assign w_own    = (PX_W'(w_owner) == pid_x);
  assign w_better = (!w_used && best_used) ||
                    (w_used && best_used && (w_stamp < best_stamp));

  assign sts.clr_last   = (cnt == FW'(FRAMES - 1));
  assign sts.scan_last  = (cnt == FW'(FRAMES - 1));
  assign sts.clr_carry  = ((rem + REM_W'(PROCS)) >= REM_W'(FRAMES));
  assign sts.adj_more   = (rem >= REM_W'(2 * FRAMES));
  assign sts.start_scan = (cmd == CMD_ACCESS) &&
                          (PX_W'(process_id) < PX_W'(PROCS));

  // clearing writes, result selection and table write-back
  always_comb begin
    res_status = STAT_NOFRAME;
    res_frame  = '0;
    res_ev     = 1'b0;
    res_evpage = '0;
    res_total  = '0;
    fr_we      = 1'b0;
    fr_waddr   = cnt;
    fr_wdata   = '0;
    fl_we      = 1'b0;
    fl_wdata   = faults_inc;
    if (ctl.clr_write) begin
      fr_we    = 1'b1;
      fr_wdata = {q, {(WORD_W-OWN_W){1'b0}}};
    end else if (ctl.finish) begin
      if (r_cmd == CMD_ASSIGN) begin
        res_status = STAT_ASSIGNED;
        res_frame  = r_fidx;
        if (pid_ok) begin
          res_total = faults_cur;
          if (fidx_ok) begin
            fr_we    = 1'b1;
            fr_waddr = fidx_x[FW-1:0];
            fr_wdata = {pid_own, {(WORD_W-OWN_W){1'b0}}};
          end
        end
      end else if (pid_ok) begin
        fr_wdata = {pid_own, 1'b1, 1'b1, r_page, r_now};
        if (hit) begin
          res_status = STAT_HIT;
          res_frame  = fidx_lo(hit_idx);
          res_total  = faults_cur;
          fr_we      = 1'b1;
          fr_waddr   = hit_idx;
        end else begin
          res_total = faults_inc;
          fl_we     = 1'b1;
          if (have) begin
            res_status = STAT_REPLACED;
            res_frame  = fidx_lo(best_idx);
            res_ev     = best_pv;
            res_evpage = best_pv ? best_page : '0;
            fr_we      = 1'b1;
            fr_waddr   = best_idx;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      rem        <= '0;
      q          <= '0;
      rd_vld     <= 1'b0;
      hit        <= 1'b0;
      have       <= 1'b0;
      done       <= 1'b0;
      faults_vld <= '0;
    end else begin
      done   <= ctl.finish;
      rd_vld <= ctl.scan_rd;
      if (ctl.clr_write) begin
        rem <= rem + REM_W'(PROCS);
      end
      if (ctl.clr_sub) begin
        rem <= rem - REM_W'(FRAMES);
        q   <= q + OWN_W'(1);
      end
      if (ctl.accept) begin
        cnt  <= '0;
        hit  <= 1'b0;
        have <= 1'b0;
      end else if (ctl.cnt_inc) begin
        cnt <= cnt + FW'(1);
      end
      if (rd_vld && w_own) begin
        if (w_pv && (w_page == r_page) && !hit) begin
          hit <= 1'b1;
        end
        if (!have || w_better) begin
          have <= 1'b1;
        end
      end
      if (fl_we) begin
        faults_vld[pid_own] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx <= cnt;
    if (ctl.accept) begin
      r_cmd  <= cmd;
      r_pid  <= process_id;
      r_page <= page;
      r_fidx <= frame_index;
      r_now  <= time_stamp;
    end
    if (rd_vld && w_own) begin
      if (w_pv && (w_page == r_page) && !hit) begin
        hit_idx <= rd_idx;
      end
      if (!have || w_better) begin
        best_idx   <= rd_idx;
        best_used  <= w_used;
        best_pv    <= w_pv;
        best_page  <= w_page;
        best_stamp <= w_stamp;
      end
    end
    if (ctl.finish) begin
      status        <= res_status;
      frame_hit     <= res_frame;
      evicted_valid <= res_ev;
      evicted_page  <= res_evpage;
      fault_total   <= res_total;
    end
  end

  lfr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (FRAMES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (cnt),
    .rdata (fr_rdata)
  );

  lfr_ram #(
    .WIDTH (FAULT_W),
    .DEPTH (PROCS)
  ) u_fault_ram (
    .clk   (clk),
    .we    (fl_we),
    .waddr (pid_own),
    .wdata (fl_wdata),
    .raddr (pid_own),
    .rdata (fl_rdata)
  );

endmodule

/* design/local_lru_frame_replacement.sv */
// Top level: local LRU frame replacement over a shared frame table.
`timescale 1ns / 1ps
// Access in range: the result strobe follows a scan of the frame table RAM, one read
//   per frame; the next start is taken in the strobe cycle.
// Assign, or access by a process at or above PROCS: no scan; wait and done states only.
// Results cannot be held off; done marks each transaction for exactly one cycle.
// Reset: synchronous; a clearing pass loads frame owners and empties the table,
//   busy high throughout.
module local_lru_frame_replacement #(
  parameter int FRAMES    = lfr_pkg::FRAMES_DEF,
  parameter int PROCS     = lfr_pkg::PROCS_DEF,
  parameter int PAGE_BITS = lfr_pkg::PAGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // request transaction
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd,
  input  logic [lfr_pkg::PID_W-1:0]     process_id,
  input  logic [PAGE_BITS-1:0]          page,
  input  logic [lfr_pkg::FIDX_W-1:0]    frame_index,
  input  logic [lfr_pkg::STAMP_W-1:0]   time_stamp,
  // result transaction
  output logic                          done,
  output logic [lfr_pkg::STATUS_W-1:0]  status,
  output logic [lfr_pkg::FIDX_W-1:0]    frame_hit,
  output logic                          evicted_valid,
  output logic [PAGE_BITS-1:0]          evicted_page,
  output logic [lfr_pkg::FAULT_W-1:0]   fault_total
);
  import lfr_pkg::*;

  // Command and status between sequencer and datapath.
  ctrl_cmd_t  ctl;
  ctrl_stat_t sts;

  // Sequencer: clearing pass after reset, then idle / scan or wait / finish per request.
  lfr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  // Datapath: one table word per frame (owner, page valid, used, page, stamp) in a
  // RAM, scanned one frame a cycle. The scan finds the first owned frame holding the
  // page and, in the same pass, the owned frame with the oldest use; never-used
  // frames win, ties keep the lowest index. Per-process fault counters sit in a
  // small RAM with a valid bit each, so reset needs no pass over them.
  lfr_datapath #(
    .FRAMES    (FRAMES),
    .PROCS     (PROCS),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .cmd           (cmd),
    .process_id    (process_id),
    .page          (page),
    .frame_index   (frame_index),
    .time_stamp    (time_stamp),
    .done          (done),
    .status        (status),
    .frame_hit     (frame_hit),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
  );

endmodule

/* design/lfr_checker.sv */
// Port-level checker for the frame replacement block, bound to the top level.
`timescale 1ns / 1ps
`include "local_lru_frame_replacement_defines.svh"
module lfr_checker #(
  parameter int PAGE_BITS = lfr_pkg::PAGE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [lfr_pkg::STATUS_W-1:0]  status,
  input logic [lfr_pkg::FIDX_W-1:0]    frame_hit,
  input logic                          evicted_valid,
  input logic [PAGE_BITS-1:0]          evicted_page
);
  import lfr_pkg::*;

  `LFR_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted request did not raise busy")
  `LFR_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "result strobe while still busy")
  `LFR_ASSERT_IMP(a_evict_status, clk, rst, done && evicted_valid, status == STAT_REPLACED, "eviction reported without a replacement")
  `LFR_ASSERT_IMP(a_noframe_zero, clk, rst, done && (status == STAT_NOFRAME), (frame_hit == '0) && !evicted_valid && (evicted_page == '0), "no-frame fault with nonzero frame or eviction")

endmodule

bind local_lru_frame_replacement lfr_checker #(
  .PAGE_BITS (PAGE_BITS)
) u_lfr_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .frame_hit     (frame_hit),
  .evicted_valid (evicted_valid),
  .evicted_page  (evicted_page)
);
